// ----- rtl/mpfq_pkg.sv -----
// Package for the multilevel priority FIFO queue.
// Holds the sizes, the item and status types and the cell types.
// No dependencies.
package mpfq_pkg;

    localparam int LEVELS   = 10;
    localparam int ENTRIES  = 64;
    localparam int ID_BITS  = 16;
    localparam int LVL_BITS = 4;

    typedef enum logic [0:0] {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_op                 operation;
        logic [ID_BITS-1:0]  item_id;
        logic [LVL_BITS-1:0] priority_req;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [ID_BITS-1:0]  out_item_id;
        logic [LVL_BITS-1:0] out_priority;
    } t_out_item;

    typedef struct packed {
        logic                valid;
        logic [LVL_BITS-1:0] lvl;
        logic [ID_BITS-1:0]  id;
    } t_entry;

    typedef struct packed {
        logic                enq;
        logic                deq;
        logic [LVL_BITS-1:0] lvl;
    } t_cell_ctl;

endpackage

// ----- rtl/mpfq_cell.sv -----
// One storage cell of the sorted queue chain.
// Depends on mpfq_pkg for the entry and control types.
module mpfq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mpfq_pkg::t_cell_ctl i_ctl,
    input  mpfq_pkg::t_entry   i_new,
    input  mpfq_pkg::t_entry   i_left,
    input  logic               i_left_keep,
    input  mpfq_pkg::t_entry   i_right,
    output mpfq_pkg::t_entry   o_entry,
    output logic               o_keep
);
    import mpfq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // A cell keeps its item on an enqueue when the item ranks at or above the new one.
    assign o_keep  = r_entry.valid && (r_entry.lvl >= i_ctl.lvl);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.enq) begin
            if (!o_keep) begin
                n_entry = i_left_keep ? i_new : i_left;
            end
        end else if (i_ctl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

// ----- rtl/multilevel_priority_fifo_queue.sv -----
// Top level of the multilevel priority FIFO queue.
// Depends on mpfq_pkg and mpfq_cell.
//
// The input channel carries one operation per item: an enqueue with an
// identifier and a priority, or a dequeue. The output channel returns one
// result item per input item, in order. Each channel uses valid and stall.
// Priorities above the top level are treated as the top level.
// The queue is a row of cells kept sorted by priority, highest at the head,
// with arrival order kept within a priority. An enqueue shifts the cells
// below its insertion point down by one; a dequeue takes the head cell and
// shifts the whole row up by one. Throughput is one item per cycle while
// the receiver does not stall; the output register is refilled in the same
// cycle that its result is taken. When the receiver stalls, the pending
// result holds and the input stalls. An enqueue into a full row is
// rejected with status full; a dequeue of an empty row returns status
// empty. Reset empties every cell and the output.
module multilevel_priority_fifo_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mpfq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mpfq_pkg::t_out_item o_out_item
);
    import mpfq_pkg::*;

    t_entry              w_entry [ENTRIES];
    logic                w_keep  [ENTRIES];
    logic [ENTRIES-1:0]  w_valid;
    t_cell_ctl           w_ctl;
    t_entry              w_new;
    logic                w_in_acc;
    logic                w_full;
    logic                w_empty;
    logic [LVL_BITS-1:0] w_lvl;

    logic                r_out_valid;
    logic                n_out_valid;
    t_out_item           r_out_item;
    t_out_item           n_out_item;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_full      = w_valid[ENTRIES-1];
    assign w_empty     = !w_valid[0];
    assign w_lvl       = (i_in_item.priority_req >= LVL_BITS'(LEVELS))
                       ? LVL_BITS'(LEVELS - 1) : i_in_item.priority_req;

    assign w_ctl.enq   = w_in_acc && (i_in_item.operation == OP_ENQ) && !w_full;
    assign w_ctl.deq   = w_in_acc && (i_in_item.operation == OP_DEQ) && !w_empty;
    assign w_ctl.lvl   = w_lvl;

    assign w_new.valid = 1'b1;
    assign w_new.lvl   = w_lvl;
    assign w_new.id    = i_in_item.item_id;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_keep;

        if (g == 0) begin : g_head
            assign w_left      = '0;
            assign w_left_keep = 1'b1;
        end else begin : g_body
            assign w_left      = w_entry[g-1];
            assign w_left_keep = w_keep[g-1];
        end

        if (g == ENTRIES - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        mpfq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_new       (w_new),
            .i_left      (w_left),
            .i_left_keep (w_left_keep),
            .i_right     (w_right),
            .o_entry     (w_entry[g]),
            .o_keep      (w_keep[g])
        );

        assign w_valid[g] = w_entry[g].valid;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        if (w_in_acc) begin
            n_out_valid             = 1'b1;
            n_out_item.out_item_id  = '0;
            n_out_item.out_priority = '0;
            if (i_in_item.operation == OP_ENQ) begin
                n_out_item.status = w_full ? ST_FULL : ST_ENQUEUED;
            end else if (w_empty) begin
                n_out_item.status = ST_EMPTY;
            end else begin
                n_out_item.status       = ST_DEQUEUED;
                n_out_item.out_item_id  = w_entry[0].id;
                n_out_item.out_priority = w_entry[0].lvl;
            end
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTH
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + ENTRIES'(1)) & w_valid) == '0)
        else $error("Occupied cells do not form a prefix of the row.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_out_valid)
        else $error("Accepted item produced no result.");

    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.enq |=> $countones(w_valid) == $countones($past(w_valid)) + 1)
        else $error("Enqueue did not add exactly one item.");

    a_deq_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.deq |=> $countones(w_valid) + 1 == $countones($past(w_valid)))
        else $error("Dequeue did not remove exactly one item.");

    a_head_is_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_entry[0].valid && w_entry[1].valid) |-> w_entry[0].lvl >= w_entry[1].lvl)
        else $error("Head item does not hold the highest priority.");
`endif

endmodule

// ----- tb/mpfq_checker.sv -----
// Checker for the multilevel priority FIFO queue: watches both channels,
// predicts each result from its own copy of the queue, and counts mismatches.
// Depends on mpfq_pkg.
module mpfq_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  mpfq_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  mpfq_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_dequeued,
    output int                  o_empties,
    output int                  o_rejects
);
    timeunit 1ns;
    timeprecision 1ps;
    import mpfq_pkg::*;

    localparam int SLOT_BITS = $clog2(ENTRIES);

    logic [ID_BITS-1:0]   slot_id    [ENTRIES];
    logic [SLOT_BITS-1:0] slot_next  [ENTRIES];
    logic [SLOT_BITS-1:0] free_slots [ENTRIES];
    logic [SLOT_BITS-1:0] lvl_head   [LEVELS];
    logic [SLOT_BITS-1:0] lvl_tail   [LEVELS];
    logic [LEVELS-1:0]    lvl_busy;
    logic [SLOT_BITS:0]   free_top;

    t_out_item awaited_results[$];
    t_out_item want;
    int        mismatches = 0;
    int        dequeued = 0;
    int        empties = 0;
    int        rejects = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic t_out_item serve_op(input t_in_item it);
        t_out_item            r;
        int                   lvl;
        logic [LVL_BITS-1:0]  lv;
        logic [SLOT_BITS-1:0] e;
        r = '0;
        r.status = ST_ENQUEUED;
        if (it.operation == OP_ENQ) begin
            lvl = (it.priority_req >= LEVELS) ? LEVELS - 1 : int'(it.priority_req);
            lv = LVL_BITS'(lvl);
            if (free_top == 0) begin
                r.status = ST_FULL;
                rejects++;
            end else begin
                free_top--;
                e = free_slots[SLOT_BITS'(free_top)];
                slot_id[e] = it.item_id;
                slot_next[e] = '0;
                if (lvl_busy[lv]) begin
                    slot_next[lvl_tail[lv]] = e;
                end else begin
                    lvl_head[lv] = e;
                    lvl_busy[lv] = 1'b1;
                end
                lvl_tail[lv] = e;
            end
        end else begin
            lvl = -1;
            for (int l = LEVELS - 1; l >= 0; l--) begin
                if (lvl < 0 && lvl_busy[l]) begin
                    lvl = l;
                end
            end
            if (lvl < 0) begin
                r.status = ST_EMPTY;
                empties++;
            end else begin
                lv = LVL_BITS'(lvl);
                e = lvl_head[lv];
                r.status = ST_DEQUEUED;
                r.out_item_id = slot_id[e];
                r.out_priority = lv;
                if (e == lvl_tail[lv]) begin
                    lvl_busy[lv] = 1'b0;
                end else begin
                    lvl_head[lv] = slot_next[e];
                end
                free_slots[SLOT_BITS'(free_top)] = e;
                free_top++;
                dequeued++;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lvl_busy = '0;
            free_top = ENTRIES;
            for (int i = 0; i < ENTRIES; i++) begin
                free_slots[i] = SLOT_BITS'(i);
            end
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result arrived with nothing awaited");
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_item.status !== want.status) begin
                        report_mismatch($sformatf("status got %0d want %0d",
                            i_out_item.status, want.status));
                    end
                    if (i_out_item.out_item_id !== want.out_item_id) begin
                        report_mismatch($sformatf("item id got %h want %h",
                            i_out_item.out_item_id, want.out_item_id));
                    end
                    if (i_out_item.out_priority !== want.out_priority) begin
                        report_mismatch($sformatf("priority got %0d want %0d",
                            i_out_item.out_priority, want.out_priority));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(serve_op(i_in_item));
            end
        end
        o_fail_count <= mismatches;
        o_pending <= awaited_results.size();
        o_dequeued <= dequeued;
        o_empties <= empties;
        o_rejects <= rejects;
    end

endmodule

// ----- tb/tb_multilevel_priority_fifo_queue.sv -----
// Testbench top for the multilevel priority FIFO queue: clock, reset,
// directed and random operations under several idle and stall mixes.
// Depends on mpfq_pkg, mpfq_checker and the queue itself.
module tb_multilevel_priority_fifo_queue;
    timeunit 1ns;
    timeprecision 1ps;
    import mpfq_pkg::*;

    localparam int PHASE_ITEMS = 130;
    localparam int STALL_LIMIT = 5000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    int fails;
    int pending;
    int dequeued;
    int empties;
    int rejects;
    int sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    multilevel_priority_fifo_queue dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    mpfq_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_dequeued   (dequeued),
        .o_empties    (empties),
        .o_rejects    (rejects)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input t_op op, input logic [ID_BITS-1:0] id,
                             input logic [LVL_BITS-1:0] pri);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{operation: op, item_id: id, priority_req: pri};
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic send_random(input int enq_pct);
        t_op                 op;
        logic [LVL_BITS-1:0] pri;
        op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
        pri = ($urandom_range(7) == 0) ? LVL_BITS'($urandom_range(15, LEVELS))
                                       : LVL_BITS'($urandom_range(LEVELS - 1));
        send_item(op, ID_BITS'($urandom), pri);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_DEQ, ID_BITS'($urandom), LVL_BITS'($urandom));
        send_item(OP_ENQ, 16'h0000, 4'd0);
        send_item(OP_ENQ, 16'hFFFF, 4'd9);
        send_item(OP_ENQ, 16'h1234, 4'd15);
        send_item(OP_ENQ, 16'h8001, 4'd10);
        send_item(OP_ENQ, 16'h0AAA, 4'd5);
        send_item(OP_ENQ, 16'h5555, 4'd5);
        send_item(OP_ENQ, 16'h7FFF, 4'd0);
        send_item(OP_ENQ, 16'hC3C3, 4'd8);
        repeat (9) send_item(OP_DEQ, ID_BITS'($urandom), LVL_BITS'($urandom));

        for (int phase = 0; phase < 8; phase++) begin
            case (phase / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            // Even phases fill the store past full, odd phases drain it past empty.
            repeat (PHASE_ITEMS) send_random((phase % 2 == 0) ? 85 : 15);
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);

        $display("Sent %0d operations: %0d dequeued, %0d on an empty queue,",
                 sent, dequeued, empties);
        $display("%0d rejected as full; idle and stall mixes: none, sender, receiver, both.",
                 rejects);
        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
